// ----- design/mrhs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and fixed-point constants of the Mehrstellen right-hand-side stencil.
package mrhs_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 24;

    // Six signed samples summed need three guard bits.
    localparam int SUM_BITS    = SAMPLE_BITS + 3;

    // One twelfth, rounded to the nearest unit of the fraction.
    localparam int K_TWELFTH   = ((1 << FRAC_BITS) + 6) / 12;
    localparam int K_BITS      = $clog2(K_TWELFTH + 1);
    localparam int PROD_BITS   = SUM_BITS + K_BITS + 1;
    localparam int ACC_BITS    = PROD_BITS + 1;
    localparam int SHIFT_BITS  = ACC_BITS - FRAC_BITS;

    localparam int DIM_X_BITS  = 13;
    localparam int DIM_YZ_BITS = 7;
    localparam int DIM_X_LIMIT = 4096;
    localparam int DIM_RESET   = 64;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = DIM_X_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DIM_X = 2'd0,
        CFG_DIM_Y = 2'd1,
        CFG_DIM_Z = 2'd2
    } t_cfg_index;

endpackage

// ----- design/mrhs_ram.sv -----
`timescale 1ns / 1ps
// Generic synchronous RAM with one write port and two registered read ports.
module mrhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8712
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr0,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr1,
    output logic [WIDTH-1:0]         o_rd_data0,
    output logic [WIDTH-1:0]         o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data0;
    logic [WIDTH-1:0] r_rd_data1;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data0 <= r_mem[i_rd_addr0];
            r_rd_data1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd_data0;
    assign o_rd_data1 = r_rd_data1;

endmodule

// ----- design/mehrstellen_rhs_stencil_3d.sv -----
`timescale 1ns / 1ps
// A result is formed in stage 1, stage 2, stage 3 and the output register, in that order.
// Throughput: one sample beat per cycle unless the output stalls; each beat does one
// write and four reads on the two identical copies of the plane store, two read ports each.
// Reset: positions, plane select, pipeline valids clear and dimensions return to 64.
// The plane store is not cleared; there is no clearing pass and no wait after reset.
module mehrstellen_rhs_stencil_3d #(
    parameter int MAX_DIM_Y = 64,
    parameter int MAX_DIM_Z = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [mrhs_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [mrhs_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    input  logic                                  i_sample_valid,
    output logic                                  o_sample_ready,
    input  mrhs_pkg::t_sample                     i_sample,
    output logic                                  o_value_valid,
    input  logic                                  i_value_ready,
    output mrhs_pkg::t_sample                     o_value,
    output logic                                  o_last
);

    localparam int YW       = $clog2(MAX_DIM_Y + 2);
    localparam int ZW       = $clog2(MAX_DIM_Z + 2);
    localparam int YEW      = ((YW > mrhs_pkg::DIM_YZ_BITS) ? YW : mrhs_pkg::DIM_YZ_BITS) + 1;
    localparam int ZEW      = ((ZW > mrhs_pkg::DIM_YZ_BITS) ? ZW : mrhs_pkg::DIM_YZ_BITS) + 1;
    localparam int XW       = mrhs_pkg::DIM_X_BITS;
    localparam int ROW_LEN  = MAX_DIM_Z + 2;
    localparam int BANK_LEN = (MAX_DIM_Y + 2) * ROW_LEN;
    localparam int DEPTH    = 2 * BANK_LEN;
    localparam int AW       = $clog2(DEPTH);
    localparam int SB       = mrhs_pkg::SAMPLE_BITS;
    localparam int FB       = mrhs_pkg::FRAC_BITS;

    function automatic logic [AW-1:0] f_addr(input logic bank, input logic [YW:0] y,
                                             input logic [ZW:0] z);
        f_addr = (bank ? AW'(BANK_LEN) : '0) + AW'(y) * AW'(ROW_LEN) + AW'(z);
    endfunction

    // Configuration
    logic [XW-1:0]                    r_dim_x;
    logic [mrhs_pkg::DIM_YZ_BITS-1:0] r_dim_y;
    logic [mrhs_pkg::DIM_YZ_BITS-1:0] r_dim_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= XW'(mrhs_pkg::DIM_RESET);
            r_dim_y <= mrhs_pkg::DIM_YZ_BITS'(mrhs_pkg::DIM_RESET);
            r_dim_z <= mrhs_pkg::DIM_YZ_BITS'(mrhs_pkg::DIM_RESET);
        end else if (i_cfg_wr_en) begin
            unique case (mrhs_pkg::t_cfg_index'(i_cfg_index))
                mrhs_pkg::CFG_DIM_X: r_dim_x <= i_cfg_wdata[XW-1:0];
                mrhs_pkg::CFG_DIM_Y: r_dim_y <= i_cfg_wdata[mrhs_pkg::DIM_YZ_BITS-1:0];
                mrhs_pkg::CFG_DIM_Z: r_dim_z <= i_cfg_wdata[mrhs_pkg::DIM_YZ_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Dimensions in use, clamped to their legal ranges.
    logic [XW-1:0]  w_ex;
    logic [YEW-1:0] w_ey;
    logic [ZEW-1:0] w_ez;

    always_comb begin
        if (r_dim_x == '0) begin
            w_ex = XW'(1);
        end else if (r_dim_x > XW'(mrhs_pkg::DIM_X_LIMIT)) begin
            w_ex = XW'(mrhs_pkg::DIM_X_LIMIT);
        end else begin
            w_ex = r_dim_x;
        end
        if (r_dim_y == '0) begin
            w_ey = YEW'(1);
        end else if (YEW'(r_dim_y) > YEW'(MAX_DIM_Y)) begin
            w_ey = YEW'(MAX_DIM_Y);
        end else begin
            w_ey = YEW'(r_dim_y);
        end
        if (r_dim_z == '0) begin
            w_ez = ZEW'(1);
        end else if (ZEW'(r_dim_z) > ZEW'(MAX_DIM_Z)) begin
            w_ez = ZEW'(MAX_DIM_Z);
        end else begin
            w_ez = ZEW'(r_dim_z);
        end
    end

    // Pipeline handshake: each stage moves when it is empty or the next one moves.
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic w_en1, w_en2, w_en3, w_en_out, w_accept;

    assign w_en_out       = !r_out_valid || i_value_ready;
    assign w_en3          = !r_s3_valid || w_en_out;
    assign w_en2          = !r_s2_valid || w_en3;
    assign w_en1          = !r_s1_valid || w_en2;
    assign o_sample_ready = i_rst_n && w_en1;
    assign w_accept       = i_sample_valid && o_sample_ready;

    // Stream position
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [ZW-1:0] r_z, n_z;
    logic          r_plane, n_plane;
    logic [YEW-1:0] w_ye;
    logic [ZEW-1:0] w_ze;
    logic           w_emit, w_last, w_zfirst;

    assign w_ye     = YEW'(r_y);
    assign w_ze     = ZEW'(r_z);
    assign w_zfirst = (r_z == '0);
    assign w_emit   = (r_x >= XW'(2)) && ({1'b0, r_x} <= {1'b0, w_ex} + (XW+1)'(1))
                   && (w_ye >= YEW'(1)) && (w_ye <= w_ey)
                   && (w_ze >= ZEW'(1)) && (w_ze <= w_ez);
    assign w_last   = ({1'b0, r_x} == {1'b0, w_ex} + (XW+1)'(1))
                   && (w_ye == w_ey) && (w_ze == w_ez);

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z + ZW'(1);
        n_plane = r_plane;
        if (w_ze > w_ez) begin
            n_z = '0;
            n_y = r_y + YW'(1);
            if (w_ye > w_ey) begin
                n_y     = '0;
                n_plane = !r_plane;
                n_x     = (r_x > w_ex) ? '0 : r_x + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_plane <= 1'b0;
        end else if (w_accept) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_plane <= n_plane;
        end
    end

    // Plane store: two copies written alike. r_plane selects the bank of plane x-2,
    // which the current sample overwrites; the other bank holds plane x-1.
    logic [YW:0]     w_y1;
    logic [ZW:0]     w_z1;
    logic            w_mid;
    logic [AW-1:0]   w_wr_addr, w_a0_addr, w_a1_addr, w_b0_addr, w_b1_addr;
    logic [SB-1:0]   w_a0_data, w_a1_data, w_b0_data, w_b1_data;

    assign w_y1      = {1'b0, r_y};
    assign w_z1      = {1'b0, r_z};
    assign w_mid     = !r_plane;
    assign w_wr_addr = f_addr(r_plane, w_y1, w_z1);
    // Copy A reads the +z neighbor, then the old-plane value; at the start of a row
    // the second port fetches the first middle-plane value of the row instead.
    assign w_a0_addr = f_addr(w_mid, w_y1, w_z1 + (ZW+1)'(1));
    assign w_a1_addr = f_addr(w_zfirst ? w_mid : r_plane, w_y1, w_z1);
    assign w_b0_addr = f_addr(w_mid, w_y1 - (YW+1)'(1), w_z1);
    assign w_b1_addr = f_addr(w_mid, w_y1 + (YW+1)'(1), w_z1);

    mrhs_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_store_a (
        .i_clk      (i_clk),
        .i_wr_en    (w_accept),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (i_sample),
        .i_rd_en    (w_accept),
        .i_rd_addr0 (w_a0_addr),
        .i_rd_addr1 (w_a1_addr),
        .o_rd_data0 (w_a0_data),
        .o_rd_data1 (w_a1_data)
    );

    mrhs_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_store_b (
        .i_clk      (i_clk),
        .i_wr_en    (w_accept),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (i_sample),
        .i_rd_en    (w_accept),
        .i_rd_addr0 (w_b0_addr),
        .i_rd_addr1 (w_b1_addr),
        .o_rd_data0 (w_b0_data),
        .o_rd_data1 (w_b1_data)
    );

    // Stage 1: store data arrives
    logic              r_s1_emit, r_s1_last, r_s1_zfirst;
    mrhs_pkg::t_sample r_s1_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= w_accept;
        end
        if (w_accept) begin
            r_s1_emit   <= w_emit;
            r_s1_last   <= w_last;
            r_s1_zfirst <= w_zfirst;
            r_s1_sample <= i_sample;
        end
    end

    // The middle-plane values along z are reused from beat to beat within a row.
    mrhs_pkg::t_sample r_zc, r_zn;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_en2) begin
            r_zc <= r_s1_zfirst ? w_a1_data : r_zn;
            r_zn <= w_a0_data;
        end
    end

    logic signed [mrhs_pkg::SUM_BITS-1:0] w_sum;
    mrhs_pkg::t_sample w_zp, w_old, w_ym, w_yp;

    assign w_zp  = w_a0_data;
    assign w_old = w_a1_data;
    assign w_ym  = w_b0_data;
    assign w_yp  = w_b1_data;
    assign w_sum = mrhs_pkg::SUM_BITS'(r_zc) + mrhs_pkg::SUM_BITS'(w_zp)
                 + mrhs_pkg::SUM_BITS'(w_old) + mrhs_pkg::SUM_BITS'(r_s1_sample)
                 + mrhs_pkg::SUM_BITS'(w_ym) + mrhs_pkg::SUM_BITS'(w_yp);

    // Stage 2: sum of the six face neighbors; the center is registered beside it
    logic signed [mrhs_pkg::SUM_BITS-1:0] r_s2_sum;
    mrhs_pkg::t_sample                    r_s2_centre;
    logic                                 r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
        if (w_en2) begin
            r_s2_sum    <= w_sum;
            r_s2_centre <= r_zn;
            r_s2_last   <= r_s1_last;
        end
    end

    // Stage 3: weight the neighbor sum by one twelfth
    logic signed [mrhs_pkg::K_BITS:0]      c_k;
    logic signed [mrhs_pkg::PROD_BITS-1:0] w_prod;
    logic signed [mrhs_pkg::PROD_BITS-1:0] r_s3_prod;
    mrhs_pkg::t_sample                     r_s3_centre;
    logic                                  r_s3_last;

    assign c_k    = (mrhs_pkg::K_BITS+1)'(mrhs_pkg::K_TWELFTH);
    assign w_prod = r_s2_sum * c_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en3) begin
            r_s3_valid <= r_s2_valid;
        end
        if (w_en3) begin
            r_s3_prod   <= w_prod;
            r_s3_centre <= r_s2_centre;
            r_s3_last   <= r_s2_last;
        end
    end

    // Add half the center, round half up, drop the fraction and saturate.
    logic signed [mrhs_pkg::ACC_BITS-1:0]   w_acc;
    logic signed [mrhs_pkg::SHIFT_BITS-1:0] w_shift;
    logic [mrhs_pkg::SHIFT_BITS-SB:0]       w_top;
    mrhs_pkg::t_sample                      w_sat;

    assign w_acc   = mrhs_pkg::ACC_BITS'(r_s3_prod)
                   + (mrhs_pkg::ACC_BITS'(r_s3_centre) <<< (FB - 1))
                   + (mrhs_pkg::ACC_BITS'(1) <<< (FB - 1));
    assign w_shift = w_acc[mrhs_pkg::ACC_BITS-1:FB];
    assign w_top   = w_shift[mrhs_pkg::SHIFT_BITS-1:SB-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            w_sat = w_shift[SB-1:0];
        end else if (w_shift[mrhs_pkg::SHIFT_BITS-1]) begin
            w_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SB-1){1'b1}}};
        end
    end

    // Output register
    mrhs_pkg::t_sample r_out_value;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_s3_valid;
        end
        if (w_en_out) begin
            r_out_value <= w_sat;
            r_out_last  <= r_s3_last;
        end
    end

    assign o_value_valid = r_out_valid;
    assign o_value       = r_out_value;
    assign o_last        = r_out_last;

endmodule

// ----- test/mrhs_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Mehrstellen stencil: it watches both channels, predicts each point and compares.
module mrhs_stencil_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mrhs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mrhs_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                                i_sample_valid,
    input  logic                                i_sample_ready,
    input  mrhs_pkg::t_sample                   i_sample,
    input  logic                                i_value_valid,
    input  logic                                i_value_ready,
    input  mrhs_pkg::t_sample                   i_value,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int     GRID_YZ_MAX    = 64;
    localparam int     ROW_WORDS      = GRID_YZ_MAX + 2;
    localparam int     BANK_WORDS     = ROW_WORDS * ROW_WORDS;
    localparam longint TWELFTH_WEIGHT = ((longint'(1) << mrhs_pkg::FRAC_BITS) + 6) / 12;
    localparam longint HALF_WEIGHT    = longint'(1) << (mrhs_pkg::FRAC_BITS - 1);
    localparam longint SAMPLE_HI      = (longint'(1) << (mrhs_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_LO      = -SAMPLE_HI - 1;

    typedef struct packed {
        mrhs_pkg::t_sample value;
        logic              last;
    } t_point;

    mrhs_pkg::t_sample                plane_mem [0:2*BANK_WORDS-1];
    t_point                           expected_points [$];
    logic [mrhs_pkg::DIM_X_BITS-1:0]  dim_x_reg;
    logic [mrhs_pkg::DIM_YZ_BITS-1:0] dim_y_reg;
    logic [mrhs_pkg::DIM_YZ_BITS-1:0] dim_z_reg;
    int                               pos_x;
    int                               pos_y;
    int                               pos_z;
    logic                             old_bank;
    int                               fail_cnt = 0;

    function automatic int clamp_dim(int raw, int hi);
        if (raw < 1) return 1;
        return (raw > hi) ? hi : raw;
    endfunction

    function automatic int word_addr(logic bank, int y, int z);
        return (bank ? BANK_WORDS : 0) + y * ROW_WORDS + z;
    endfunction

    // The sum is exact in units of 2^-24; rounding is half up, then saturation.
    function automatic mrhs_pkg::t_sample weigh_point(longint face_sum, longint centre);
        longint acc;
        acc = face_sum * TWELFTH_WEIGHT + centre * HALF_WEIGHT + HALF_WEIGHT;
        acc = acc >>> mrhs_pkg::FRAC_BITS;
        if (acc > SAMPLE_HI) acc = SAMPLE_HI;
        if (acc < SAMPLE_LO) acc = SAMPLE_LO;
        return mrhs_pkg::t_sample'(acc);
    endfunction

    // The arriving sample is the +x neighbour of the point at the same y and z one plane back.
    task automatic absorb_sample(input mrhs_pkg::t_sample s);
        int     ex;
        int     ey;
        int     ez;
        logic   mid;
        longint face_sum;
        t_point pt;
        ex  = clamp_dim(int'(dim_x_reg), mrhs_pkg::DIM_X_LIMIT);
        ey  = clamp_dim(int'(dim_y_reg), GRID_YZ_MAX);
        ez  = clamp_dim(int'(dim_z_reg), GRID_YZ_MAX);
        mid = ~old_bank;
        if (pos_x >= 2 && pos_x <= ex + 1 && pos_y >= 1 && pos_y <= ey
                && pos_z >= 1 && pos_z <= ez) begin
            face_sum = longint'(plane_mem[word_addr(mid, pos_y, pos_z - 1)])
                     + longint'(plane_mem[word_addr(mid, pos_y, pos_z + 1)])
                     + longint'(plane_mem[word_addr(mid, pos_y - 1, pos_z)])
                     + longint'(plane_mem[word_addr(mid, pos_y + 1, pos_z)])
                     + longint'(plane_mem[word_addr(old_bank, pos_y, pos_z)])
                     + longint'(s);
            pt.value = weigh_point(face_sum, longint'(plane_mem[word_addr(mid, pos_y, pos_z)]));
            pt.last  = (pos_x == ex + 1 && pos_y == ey && pos_z == ez);
            expected_points.push_back(pt);
        end
        plane_mem[word_addr(old_bank, pos_y, pos_z)] = s;
        if (pos_z + 1 >= ez + 2) begin
            pos_z = 0;
            if (pos_y + 1 >= ey + 2) begin
                pos_y    = 0;
                old_bank = ~old_bank;
                pos_x    = (pos_x + 1 >= ex + 2) ? 0 : pos_x + 1;
            end else begin
                pos_y++;
            end
        end else begin
            pos_z++;
        end
    endtask

    task automatic check_result();
        t_point want;
        if (expected_points.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got value %h last %b",
                     $time, i_value, i_last);
            fail_cnt++;
        end else begin
            want = expected_points.pop_front();
            if (i_value !== want.value) begin
                $display("%0t: value expected %h, got %h", $time, want.value, i_value);
                fail_cnt++;
            end
            if (i_last !== want.last) begin
                $display("%0t: last expected %b, got %b", $time, want.last, i_last);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dim_x_reg = mrhs_pkg::DIM_X_BITS'(mrhs_pkg::DIM_RESET);
            dim_y_reg = mrhs_pkg::DIM_YZ_BITS'(mrhs_pkg::DIM_RESET);
            dim_z_reg = mrhs_pkg::DIM_YZ_BITS'(mrhs_pkg::DIM_RESET);
            pos_x     = 0;
            pos_y     = 0;
            pos_z     = 0;
            old_bank  = 1'b0;
            expected_points.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mrhs_pkg::CFG_DIM_X:
                        dim_x_reg = i_cfg_wdata[mrhs_pkg::DIM_X_BITS-1:0];
                    mrhs_pkg::CFG_DIM_Y:
                        dim_y_reg = i_cfg_wdata[mrhs_pkg::DIM_YZ_BITS-1:0];
                    mrhs_pkg::CFG_DIM_Z:
                        dim_z_reg = i_cfg_wdata[mrhs_pkg::DIM_YZ_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_value_valid && i_value_ready) check_result();
            if (i_sample_valid && i_sample_ready) absorb_sample(i_sample);
        end
        o_pending    <= expected_points.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the stencil testbench: clock, reset, grid stimulus, idling and the final verdict.
module testbench;

    localparam logic [mrhs_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int                RANDOM_ITEMS    = 780;
    localparam int                SETTLE_CYCLES   = 8;
    localparam int                WATCHDOG_CYCLES = 2000;
    localparam int                GRID_YZ_MAX     = 64;
    localparam mrhs_pkg::t_sample SAMPLE_MAX      = mrhs_pkg::t_sample'(32'h7FFF_FFFF);
    localparam mrhs_pkg::t_sample SAMPLE_MIN      = mrhs_pkg::t_sample'(32'h8000_0000);

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_cfg_wr_en    = 1'b0;
    logic [mrhs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index    = '0;
    logic [mrhs_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata    = '0;
    logic                                i_sample_valid = 1'b0;
    mrhs_pkg::t_sample                   i_sample       = '0;
    logic                                i_value_ready  = 1'b0;
    logic                                o_sample_ready;
    logic                                o_value_valid;
    mrhs_pkg::t_sample                   o_value;
    logic                                o_last;
    int                                  fail_count;
    int                                  pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int beats_sent     = 0;
    // Padded position of the next beat and the raw register values, for grid bookkeeping.
    int grid_x = 0;
    int grid_y = 0;
    int grid_z = 0;
    int set_x  = mrhs_pkg::DIM_RESET;
    int set_y  = mrhs_pkg::DIM_RESET;
    int set_z  = mrhs_pkg::DIM_RESET;

    mehrstellen_rhs_stencil_3d dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_value_valid  (o_value_valid),
        .i_value_ready  (i_value_ready),
        .o_value        (o_value),
        .o_last         (o_last)
    );

    mrhs_stencil_checker stencil_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_valid (i_sample_valid),
        .i_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .i_value_valid  (o_value_valid),
        .i_value_ready  (i_value_ready),
        .i_value        (o_value),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_value_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_sample_valid && o_sample_ready) || (o_value_valid && i_value_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int eff_dim(int raw, int hi);
        if (raw < 1) return 1;
        return (raw > hi) ? hi : raw;
    endfunction

    function automatic int padded_count();
        return (eff_dim(set_x, mrhs_pkg::DIM_X_LIMIT) + 2) * (eff_dim(set_y, GRID_YZ_MAX) + 2)
             * (eff_dim(set_z, GRID_YZ_MAX) + 2);
    endfunction

    // Small grids keep the random part dense in results; a zero now and then tests the clamp.
    function automatic int rand_dim();
        return ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 4));
    endfunction

    function automatic int rand_dim_upto(int hi);
        return ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, hi));
    endfunction

    function automatic mrhs_pkg::t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return mrhs_pkg::t_sample'(int'($urandom_range(0, 511)) - 256);
            default: return mrhs_pkg::t_sample'($urandom());
        endcase
    endfunction

    task automatic set_idle(input t_idle_mode m);
        case (m)
            IDLE_SENDER:   begin send_idle_pct = 63; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            IDLE_BOTH:     begin send_idle_pct = 35; recv_stall_pct = 35; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic write_reg(input logic [mrhs_pkg::CFG_INDEX_BITS-1:0] idx, input int data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= mrhs_pkg::CFG_DATA_BITS'(data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            mrhs_pkg::CFG_DIM_X: set_x = data & 32'h1FFF;
            mrhs_pkg::CFG_DIM_Y: set_y = data & 32'h7F;
            mrhs_pkg::CFG_DIM_Z: set_z = data & 32'h7F;
            default: ;
        endcase
    endtask

    task automatic write_dims(input int x, input int y, input int z);
        write_reg(mrhs_pkg::CFG_DIM_X, x);
        write_reg(mrhs_pkg::CFG_DIM_Y, y);
        write_reg(mrhs_pkg::CFG_DIM_Z, z);
    endtask

    task automatic push_sample(input mrhs_pkg::t_sample v);
        int ex;
        int ey;
        int ez;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= v;
        @(posedge i_clk);
        while (!o_sample_ready) @(posedge i_clk);
        beats_sent++;
        ex = eff_dim(set_x, mrhs_pkg::DIM_X_LIMIT);
        ey = eff_dim(set_y, GRID_YZ_MAX);
        ez = eff_dim(set_z, GRID_YZ_MAX);
        if (grid_z + 1 >= ez + 2) begin
            grid_z = 0;
            if (grid_y + 1 >= ey + 2) begin
                grid_y = 0;
                grid_x = (grid_x + 1 >= ex + 2) ? 0 : grid_x + 1;
            end else begin
                grid_y++;
            end
        end else begin
            grid_z++;
        end
    endtask

    task automatic finish_grid();
        do push_sample(pick_sample());
        while (grid_x != 0 || grid_y != 0 || grid_z != 0);
    endtask

    // The sender holds off until every expected point is back and the pipeline is empty.
    task automatic drain_results();
        i_sample_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stops partway through a grid, changes the dimensions and streams on to the origin.
    task automatic run_split_grid();
        int cut;
        int keep_y;
        int keep_z;
        write_dims(rand_dim(), rand_dim(), rand_dim());
        keep_y = eff_dim(set_y, GRID_YZ_MAX);
        keep_z = eff_dim(set_z, GRID_YZ_MAX);
        cut = $urandom_range(1, padded_count() - 1);
        repeat (cut) push_sample(pick_sample());
        drain_results();
        // Planes no larger than the ones already streamed only touch words of this grid.
        write_dims(rand_dim(), rand_dim_upto(keep_y), rand_dim_upto(keep_z));
        finish_grid();
        drain_results();
    endtask

    initial begin
        int grid_idx;
        int first_random;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A single interior point: its seven taps at the largest value, the unused halo
        // corners and edges at the smallest.
        set_idle(IDLE_NONE);
        write_dims(1, 1, 1);
        for (int idx = 0; idx < 27; idx++) begin
            case (idx)
                4, 10, 12, 13, 14, 16, 22: push_sample(SAMPLE_MAX);
                default:                   push_sample(SAMPLE_MIN);
            endcase
        end
        drain_results();
        write_reg(CFG_SPARE, $urandom_range(0, 8191));

        grid_idx     = 0;
        first_random = beats_sent;
        while (beats_sent - first_random < RANDOM_ITEMS) begin
            set_idle(t_idle_mode'(grid_idx % 4));
            if (grid_idx % 5 == 4) begin
                run_split_grid();
            end else begin
                write_dims(rand_dim(), rand_dim(), rand_dim());
                finish_grid();
                drain_results();
            end
            grid_idx++;
        end

        set_idle(IDLE_NONE);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
